/* rtl/core/uist_pkg.sv */
`timescale 1ns / 1ps

package uist_pkg;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // table depth, tied to the position and element_count field widths
    localparam int CAPACITY = 64;

    // input tdata: value, position; output tdata: status, read_value, element_count
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - STATUS_W - VALUE_W - COUNT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_DUP     = 3'd1,
        STAT_ABSENT  = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_BAD_IDX = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

endpackage

/* rtl/core/unique_integer_set_table.sv */
`timescale 1ns / 1ps

// channel        dir  tvalid/tready                      payload
// s_axis         in   i_s_axis_tvalid/o_s_axis_tready    tuser: kind; tdata: value, position
// m_axis         out  o_m_axis_tvalid/i_m_axis_tready    tdata: status, read_value, element_count
//
// one transaction in, one transaction out, one item at a time; s_axis is ready only when idle
// insert and lookup scan the table through the single memory read port and one comparator;
// delete scans then moves the later entries down one per cycle on the same port; read by
// index reads the entry through the same port, or reports a bad index past the count
// a finished result waits in the output register until m_axis takes it
// i_rst_n is synchronous, active low; it clears the count and the sequencer, not the memory

module unique_integer_set_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] value, [37:32] position, [39:38] zero
    input  logic [uist_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [1:0] kind
    input  logic [uist_pkg::KIND_W-1:0]        i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [2:0] status, [34:3] read_value, [41:35] element_count, [47:42] zero
    output logic [uist_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    import uist_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    t_state                     r_state, n_state;
    t_kind                      r_kind, n_kind;
    logic signed [VALUE_W-1:0]  r_value, n_value;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_addr, n_addr;
    logic                       r_pend, n_pend;
    logic [AW-1:0]              r_pend_idx, n_pend_idx;
    t_status                    r_status, n_status;
    logic signed [VALUE_W-1:0]  r_rd_value, n_rd_value;

    logic signed [VALUE_W-1:0]  r_mem [CAPACITY];
    logic signed [VALUE_W-1:0]  r_rdata;
    logic                       w_re;
    logic [AW-1:0]              w_raddr;
    logic                       w_we;
    logic [AW-1:0]              w_waddr;
    logic signed [VALUE_W-1:0]  w_wdata;

    logic                       w_match;
    logic                       w_more;
    logic                       w_in_acc;

    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_match  = r_pend && (r_rdata == r_value);
    assign w_more   = r_addr < r_count;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_DONE);
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, COUNT_W'(r_count), r_rd_value, r_status};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_pos      <= n_pos;
        r_addr     <= n_addr;
        r_pend_idx <= n_pend_idx;
        r_status   <= n_status;
        r_rd_value <= n_rd_value;
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_value    = r_value;
        n_pos      = r_pos;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_status   = r_status;
        n_rd_value = r_rd_value;
        w_re       = 1'b0;
        w_raddr    = r_addr[AW-1:0];
        w_we       = 1'b0;
        w_waddr    = r_pend_idx - AW'(1);
        w_wdata    = r_rdata;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_kind     = t_kind'(i_s_axis_tuser);
                    n_value    = i_s_axis_tdata[VALUE_W-1:0];
                    n_pos      = i_s_axis_tdata[VALUE_W +: POS_W];
                    n_addr     = '0;
                    n_status   = STAT_OK;
                    n_rd_value = '0;
                    n_state    = (t_kind'(i_s_axis_tuser) == KIND_READ) ? ST_READ : ST_SCAN;
                end
            end

            // one read issued per cycle, its data compared against the value in the cycle after
            ST_SCAN: begin
                if (w_match) begin
                    unique case (r_kind)
                        KIND_INSERT: begin
                            n_status = STAT_DUP;
                            n_state  = ST_DONE;
                        end
                        KIND_DELETE: begin
                            n_addr  = CW'(r_pend_idx) + CW'(1);
                            n_state = ST_SHIFT;
                        end
                        default: begin
                            n_status = STAT_OK;
                            n_state  = ST_DONE;
                        end
                    endcase
                end else if (w_more) begin
                    w_re       = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_addr[AW-1:0];
                    n_addr     = r_addr + CW'(1);
                end else if (!r_pend) begin
                    n_state = ST_DONE;
                    if (r_kind == KIND_INSERT) begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_status = STAT_FULL;
                        end else begin
                            w_we     = 1'b1;
                            w_waddr  = r_count[AW-1:0];
                            w_wdata  = r_value;
                            n_count  = r_count + CW'(1);
                            n_status = STAT_OK;
                        end
                    end else begin
                        n_status = STAT_ABSENT;
                    end
                end
            end

            // read entry k while entry k-2 is written with entry k-1, read the cycle before
            ST_SHIFT: begin
                if (r_pend) begin
                    w_we = 1'b1;
                end
                if (w_more) begin
                    w_re       = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_addr[AW-1:0];
                    n_addr     = r_addr + CW'(1);
                end else if (!r_pend) begin
                    n_count  = r_count - CW'(1);
                    n_status = STAT_OK;
                    n_state  = ST_DONE;
                end
            end

            ST_READ: begin
                if (CMPW'(r_pos) < CMPW'(r_count)) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_pos);
                    n_state = ST_READ_WAIT;
                end else begin
                    n_status = STAT_BAD_IDX;
                    n_state  = ST_DONE;
                end
            end

            ST_READ_WAIT: begin
                n_rd_value = r_rdata;
                n_status   = STAT_OK;
                n_state    = ST_DONE;
            end

            ST_DONE: begin
                if (i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == ST_SCAN || r_state == ST_SHIFT))
        else $error("table written outside scan or shift");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> ($past(r_state) == ST_SCAN || $past(r_state) == ST_SHIFT))
        else $error("count changed outside insert or delete");

    a_shift_write_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && r_pend) |-> (r_pend_idx != '0))
        else $error("shift writes below entry zero");

endmodule
